@@ rtl/mpfd_pkg.sv @@
// Shared types, constants and field layouts for the mesh packet forward decision core.
// Used by the top level, the route table RAM instance and the port checker.
// No dependencies.
package mpfd_pkg;

    // Table geometry
    localparam int NODE_COUNT  = 32;
    localparam int ROUTE_SLOTS = 3;
    localparam int MAX_HOPS    = 4;

    // Field widths
    localparam int ADDR_W  = 5;
    localparam int PROTO_W = 3;
    localparam int HCNT_W  = 2;
    localparam int HOP_W   = 5;
    localparam int LIST_N  = 4;
    localparam int LIST_W  = HOP_W * LIST_N;
    localparam int PORT_W  = 8;
    localparam int MASK_W  = 32;

    // Derived storage sizes
    localparam int ROW_W    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int SLOT_W   = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
    localparam int RROW_W   = LIST_W * ROUTE_SLOTS;

    // Stream widths
    localparam int ITEM_W   = 2 * ADDR_W + HCNT_W + 1 + LIST_W + 2 * PORT_W + LIST_W;
    localparam int S_DATA_W = ((ITEM_W + 7) / 8) * 8;
    localparam int RES_W    = PORT_W + HCNT_W + LIST_W;
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MY_ADDRESS = 4'd0,
        CFG_PROTO_RIP  = 4'd1,
        CFG_PROTO_UDP  = 4'd2,
        CFG_PORT_MASK  = 4'd3
    } cfg_idx_t;

    // Result action, carried on m_tuser
    typedef enum logic [1:0] {
        ACT_DROP    = 2'd0,
        ACT_DELIVER = 2'd1,
        ACT_FORWARD = 2'd2,
        ACT_UPDATE  = 2'd3
    } action_t;

    // Input item as packed in s_tdata (last member lands in the lowest bits)
    typedef struct packed {
        logic [LIST_W-1:0] advertised_hops;
        logic [PORT_W-1:0] dst_port;
        logic [PORT_W-1:0] src_port;
        logic [LIST_W-1:0] hop_list;
        logic              auto_route;
        logic [HCNT_W-1:0] hop_count;
        logic [ADDR_W-1:0] dst_addr;
        logic [ADDR_W-1:0] src_addr;
    } item_t;

    // Result as packed in m_tdata
    typedef struct packed {
        logic [LIST_W-1:0] hop_list_out;
        logic [HCNT_W-1:0] hop_count_out;
        logic [PORT_W-1:0] deliver_port;
    } result_t;

endpackage

@@ rtl/mpfd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; used for the route table.
module mpfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/mesh_packet_forward_decision_core.sv @@
// Mesh packet forward decision core: top level with config registers, decision stage
// and result register. Depends on mpfd_pkg and mpfd_ram.
//
// One header enters per transfer on s_ and one decision leaves per transfer on m_.
// Sustained rate is one item per clock while m_ is not stalled; the table read and the
// decision stage register feed the result register, which drives m_tvalid. The
// route table is a RAM of one row per node (all route slots side by side). It is read
// once per item at input time and written back only for an update in the decision stage.
// A forwarding register covers a row written by the item just ahead. Per-row valid bits
// make the table read as all zero after reset, so no clearing pass is needed.
// Configuration writes are taken every cycle (cfg_ready is always high) and must only
// occur while the core is idle.
module mesh_packet_forward_decision_core
    import mpfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input headers
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata from bit 0: src_addr, dst_addr, hop_count, auto_route, hop_list,
    // src_port, dst_port, advertised_hops, zero fill
    input  logic [S_DATA_W-1:0]   s_tdata,
    // s_tuser: protocol
    input  logic [PROTO_W-1:0]    s_tuser,
    // Decisions
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata from bit 0: deliver_port, hop_count_out, hop_list_out, zero fill
    output logic [M_DATA_W-1:0]   m_tdata,
    // m_tuser: action
    output logic [1:0]            m_tuser
);

    // Configuration registers
    logic [ADDR_W-1:0]  my_addr_reg;
    logic [PROTO_W-1:0] rip_code_reg;
    logic [PROTO_W-1:0] udp_code_reg;
    logic [MASK_W-1:0]  port_mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            my_addr_reg   <= '0;
            rip_code_reg  <= PROTO_W'(1);
            udp_code_reg  <= PROTO_W'(3);
            port_mask_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_MY_ADDRESS: my_addr_reg   <= cfg_data[ADDR_W-1:0];
                CFG_PROTO_RIP:  rip_code_reg  <= cfg_data[PROTO_W-1:0];
                CFG_PROTO_UDP:  udp_code_reg  <= cfg_data[PROTO_W-1:0];
                CFG_PORT_MASK:  port_mask_reg <= cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake control
    logic stg_vld_reg, stg_vld_next;
    logic m_vld_reg;
    logic out_free;
    logic in_acc;
    logic done;

    assign out_free = !m_vld_reg || m_tready;
    assign s_tready = !stg_vld_reg || out_free;
    assign in_acc   = s_tvalid && s_tready;
    assign done     = stg_vld_reg && out_free;

    // Row lookup issued at input transfer time
    item_t            in_item;
    logic [ADDR_W-1:0] in_sel_addr;
    logic [ROW_W-1:0]  in_row;
    logic              in_rng;

    assign in_item     = item_t'(s_tdata[ITEM_W-1:0]);
    assign in_sel_addr = (in_item.dst_addr == my_addr_reg) ? in_item.src_addr
                                                           : in_item.dst_addr;
    assign in_row      = ROW_W'(in_sel_addr);
    assign in_rng      = (32'(in_sel_addr) < NODE_COUNT);

    // Decision stage registers
    item_t              stg_item_reg;
    logic [PROTO_W-1:0] stg_proto_reg;
    logic [ROW_W-1:0]   stg_row_reg;
    logic               stg_rng_reg;

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            stg_item_reg  <= in_item;
            stg_proto_reg <= s_tuser;
            stg_row_reg   <= in_row;
            stg_rng_reg   <= in_rng;
        end
    end

    always_comb begin
        stg_vld_next = stg_vld_reg;
        if (in_acc) begin
            stg_vld_next = 1'b1;
        end else if (done) begin
            stg_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_vld_reg <= 1'b0;
        end else begin
            stg_vld_reg <= stg_vld_next;
        end
    end

    // Route table storage
    logic              wr_en;
    logic [RROW_W-1:0] wr_row_data;
    logic [RROW_W-1:0] rd_row_data;

    mpfd_ram #(
        .WIDTH (RROW_W),
        .DEPTH (NODE_COUNT)
    ) u_route_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (stg_row_reg),
        .wr_data (wr_row_data),
        .rd_en   (in_acc),
        .rd_addr (in_row),
        .rd_data (rd_row_data)
    );

    // Row valid bits and write forwarding
    logic [NODE_COUNT-1:0] row_vld_reg;
    logic                  fwd_vld_reg;
    logic [ROW_W-1:0]      fwd_row_reg;
    logic [RROW_W-1:0]     fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            fwd_vld_reg <= 1'b0;
        end else if (wr_en) begin
            row_vld_reg[stg_row_reg] <= 1'b1;
            fwd_vld_reg              <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fwd_row_reg  <= stg_row_reg;
            fwd_data_reg <= wr_row_data;
        end
    end

    // Effective row contents seen by the item in the decision stage
    logic [RROW_W-1:0] row_data;

    always_comb begin
        row_data = '0;
        if (stg_rng_reg) begin
            if (fwd_vld_reg && (fwd_row_reg == stg_row_reg)) begin
                row_data = fwd_data_reg;
            end else if (row_vld_reg[stg_row_reg]) begin
                row_data = rd_row_data;
            end
        end
    end

    // Decision logic
    action_t           act;
    result_t           res;
    logic              slot_found;
    logic [SLOT_W-1:0] slot_sel;
    logic [HOP_W-1:0]  cur_hop;
    logic [HOP_W-1:0]  next_hop;
    logic [HCNT_W-1:0] nh;
    logic [LIST_W-1:0] row0;
    logic [PORT_W-1:0] en_bit;
    logic              port_en;

    // First empty slot of the row (hop 0 equal to zero)
    always_comb begin
        slot_found = 1'b0;
        slot_sel   = '0;
        for (int s = 0; s < ROUTE_SLOTS; s++) begin
            if (!slot_found && (row_data[s*LIST_W +: HOP_W] == '0)) begin
                slot_found = 1'b1;
                slot_sel   = SLOT_W'(s);
            end
        end
    end

    // Row with the advertised route placed in the empty slot
    always_comb begin
        wr_row_data = row_data;
        for (int s = 0; s < ROUTE_SLOTS; s++) begin
            if (slot_sel == SLOT_W'(s)) begin
                wr_row_data[s*LIST_W +: LIST_W] = stg_item_reg.advertised_hops;
            end
        end
    end

    // Current hop, and next hop taken from slot 0 of the destination row
    assign nh   = stg_item_reg.hop_count + HCNT_W'(1);
    assign row0 = row_data[LIST_W-1:0];

    always_comb begin
        cur_hop  = '0;
        next_hop = '0;
        for (int h = 0; h < LIST_N; h++) begin
            if (stg_item_reg.hop_count == HCNT_W'(h)) begin
                cur_hop = stg_item_reg.hop_list[h*HOP_W +: HOP_W];
            end
            if (nh == HCNT_W'(h)) begin
                next_hop = row0[h*HOP_W +: HOP_W];
            end
        end
    end

    // Port enable: port 31 when the destination port is above 31, else the source port
    assign en_bit  = (stg_item_reg.dst_port > PORT_W'(31)) ? PORT_W'(31)
                                                           : stg_item_reg.src_port;
    assign port_en = (en_bit < PORT_W'(MASK_W)) && port_mask_reg[en_bit[4:0]];

    always_comb begin
        act   = ACT_DROP;
        res   = '0;
        wr_en = 1'b0;
        if (stg_item_reg.dst_addr == my_addr_reg) begin
            if (stg_proto_reg == rip_code_reg) begin
                if (stg_rng_reg && slot_found) begin
                    act   = ACT_UPDATE;
                    wr_en = done;
                end
            end else if (stg_proto_reg == udp_code_reg) begin
                if (port_en) begin
                    act              = ACT_DELIVER;
                    res.deliver_port = stg_item_reg.src_port;
                end
            end
        end else if ((cur_hop != '0) &&
                     (32'(stg_item_reg.hop_count) < (MAX_HOPS - 1))) begin
            act               = ACT_FORWARD;
            res.hop_count_out = nh;
            res.hop_list_out  = stg_item_reg.hop_list;
            if (stg_item_reg.auto_route) begin
                for (int h = 0; h < LIST_N; h++) begin
                    if (nh == HCNT_W'(h)) begin
                        res.hop_list_out[h*HOP_W +: HOP_W] = next_hop;
                    end
                end
            end
        end
    end

    // Result register
    logic [M_DATA_W-1:0] m_data_reg;
    logic [1:0]          m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (done) begin
            m_vld_reg <= 1'b1;
        end else if (m_tready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_data_reg <= M_DATA_W'(res);
            m_user_reg <= act;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

@@ rtl/mpfd_checker.sv @@
// Port-level checker for the mesh packet forward decision core, and its bind.
// Depends on mpfd_pkg; sees only the top level's ports.
module mpfd_checker
    import mpfd_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_DATA_W-1:0]   s_tdata,
    input logic [PROTO_W-1:0]    s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata,
    input logic [1:0]            m_tuser
);

    // A stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No result leaves reset pending
    a_rst_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Drops and table updates carry all-zero fields
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ACT_DROP || m_tuser == ACT_UPDATE) |-> m_tdata == '0)
        else $error("drop or update with nonzero fields");

    // Delivery carries only a port
    a_deliver: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ACT_DELIVER |-> m_tdata[M_DATA_W-1:PORT_W] == '0)
        else $error("delivery with hop fields set");

    // Forward has no port and a nonzero hop count
    a_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ACT_FORWARD |->
            m_tdata[PORT_W-1:0] == '0 && m_tdata[PORT_W +: HCNT_W] != '0)
        else $error("malformed forward result");

endmodule

bind mesh_packet_forward_decision_core mpfd_checker u_mpfd_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for mesh_packet_forward_decision_core.
// Drives headers and register writes, predicts each decision and checks it.
// Depends on mpfd_pkg and the core RTL only.
module testbench
    import mpfd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam time HALF_PERIOD   = 5ns;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  QUIET_LIMIT   = 4000;
    localparam int  LONG_STALL    = 400;
    localparam int  PHASE_ITEMS   = 250;
    localparam int  PHASES        = 6;

    // Register values at reset
    localparam logic [PROTO_W-1:0] RIP_AT_RESET = 3'd1;
    localparam logic [PROTO_W-1:0] UDP_AT_RESET = 3'd3;

    // Directed part setup
    localparam logic [ADDR_W-1:0]  DIR_NODE     = 5'd5;
    localparam logic [PROTO_W-1:0] DIR_RIP      = 3'd1;
    localparam logic [PROTO_W-1:0] DIR_UDP      = 3'd3;
    localparam logic [PROTO_W-1:0] DIR_SHARED   = 3'd6;
    localparam logic [PROTO_W-1:0] DIR_OTHER_HI = 3'd7;
    localparam logic [PROTO_W-1:0] DIR_OTHER_LO = 3'd0;
    localparam logic [MASK_W-1:0]  DIR_MASK     = 32'h8000_0005;

    typedef struct {
        action_t act;
        result_t res;
    } decision_t;

    // Scoreboard: keeps its own route table and registers, queues expected decisions
    class decision_scoreboard;
        logic [ADDR_W-1:0]  my_addr;
        logic [PROTO_W-1:0] rip_code;
        logic [PROTO_W-1:0] udp_code;
        logic [MASK_W-1:0]  port_mask;
        logic [LIST_W-1:0]  routes [NODE_COUNT][ROUTE_SLOTS];
        decision_t          awaited_q [$];
        int                 errors;
        int                 seen;

        function new();
            my_addr   = '0;
            rip_code  = RIP_AT_RESET;
            udp_code  = UDP_AT_RESET;
            port_mask = '0;
            errors    = 0;
            seen      = 0;
            foreach (routes[r, s]) routes[r][s] = '0;
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        function int pending();
            return awaited_q.size();
        endfunction

        function void apply_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_MY_ADDRESS: my_addr   = val[ADDR_W-1:0];
                CFG_PROTO_RIP:  rip_code  = val[PROTO_W-1:0];
                CFG_PROTO_UDP:  udp_code  = val[PROTO_W-1:0];
                CFG_PORT_MASK:  port_mask = val[MASK_W-1:0];
                default: ;
            endcase
        endfunction

        // Work out the decision for one accepted header
        function void note_header(item_t hdr, logic [PROTO_W-1:0] proto);
            decision_t         d;
            bit                stored;
            int                sel;
            int                nh;
            logic [LIST_W-1:0] row;
            d.act  = ACT_DROP;
            d.res  = '0;
            stored = 1'b0;
            if (hdr.dst_addr == my_addr) begin
                if (proto == rip_code) begin
                    // first slot whose hop 0 is zero takes the advertised route
                    if (hdr.src_addr < NODE_COUNT) begin
                        for (int s = 0; s < ROUTE_SLOTS; s++) begin
                            if (!stored && routes[hdr.src_addr][s][HOP_W-1:0] == '0) begin
                                routes[hdr.src_addr][s] = hdr.advertised_hops;
                                stored = 1'b1;
                            end
                        end
                    end
                    if (stored) d.act = ACT_UPDATE;
                end else if (proto == udp_code) begin
                    // high destination port selects enable bit 31
                    sel = (hdr.dst_port > 31) ? 31 : int'(hdr.src_port);
                    if (sel < MASK_W && port_mask[sel]) begin
                        d.act              = ACT_DELIVER;
                        d.res.deliver_port = hdr.src_port;
                    end
                end
            end else if (hdr.hop_list[hdr.hop_count*HOP_W +: HOP_W] != '0 &&
                         hdr.hop_count < MAX_HOPS - 1) begin
                nh                 = hdr.hop_count + 1;
                d.res.hop_list_out = hdr.hop_list;
                if (hdr.auto_route) begin
                    row = '0;
                    if (hdr.dst_addr < NODE_COUNT) row = routes[hdr.dst_addr][0];
                    d.res.hop_list_out[nh*HOP_W +: HOP_W] = row[nh*HOP_W +: HOP_W];
                end
                d.act               = ACT_FORWARD;
                d.res.hop_count_out = nh[HCNT_W-1:0];
            end
            awaited_q.insert(awaited_q.size(), d);
        endfunction

        // Compare one accepted decision against the oldest expectation
        task check_result(logic [1:0] act, logic [M_DATA_W-1:0] data);
            result_t   got;
            decision_t want;
            got = data[RES_W-1:0];
            seen++;
            if (awaited_q.size() == 0) begin
                report($sformatf("decision %0d arrived with none expected", seen));
                return;
            end
            want = awaited_q.pop_front();
            if (act !== want.act)
                report($sformatf("decision %0d: action %0d, expected %0d",
                                 seen, act, want.act));
            if (got.deliver_port !== want.res.deliver_port)
                report($sformatf("decision %0d: deliver_port %0d, expected %0d",
                                 seen, got.deliver_port, want.res.deliver_port));
            if (got.hop_count_out !== want.res.hop_count_out)
                report($sformatf("decision %0d: hop_count_out %0d, expected %0d",
                                 seen, got.hop_count_out, want.res.hop_count_out));
            if (got.hop_list_out !== want.res.hop_list_out)
                report($sformatf("decision %0d: hop_list_out %h, expected %h",
                                 seen, got.hop_list_out, want.res.hop_list_out));
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [PROTO_W-1:0]    s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [1:0]            m_tuser;

    decision_scoreboard decisions;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int quiet_cycles  = 0;
    bit stall_request = 1'b0;

    mesh_packet_forward_decision_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Result side: random backpressure, plus one long hold-off on request
    initial begin : rx_side
        forever begin
            @(posedge aclk);
            if (stall_request) begin
                stall_request <= 1'b0;
                m_tready      <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Check every decision transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) decisions.check_result(m_tuser, m_tdata);
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic item_t make_hdr(
        logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst, logic [HCNT_W-1:0] hops,
        logic autor, logic [LIST_W-1:0] hop_list, logic [PORT_W-1:0] sport,
        logic [PORT_W-1:0] dport, logic [LIST_W-1:0] adv);
        item_t hdr;
        hdr.src_addr        = src;
        hdr.dst_addr        = dst;
        hdr.hop_count       = hops;
        hdr.auto_route      = autor;
        hdr.hop_list        = hop_list;
        hdr.src_port        = sport;
        hdr.dst_port        = dport;
        hdr.advertised_hops = adv;
        return hdr;
    endfunction

    // Mostly well-formed updates, datagrams and transit packets, some pure noise
    function automatic void random_header(output item_t hdr, output logic [PROTO_W-1:0] proto);
        logic [95:0] bits;
        int          kind;
        bits  = {$urandom, $urandom, $urandom};
        hdr   = bits[ITEM_W-1:0];
        proto = PROTO_W'($urandom_range(7));
        kind  = $urandom_range(99);
        if (kind < 20) begin
            hdr.dst_addr = decisions.my_addr;
            proto        = decisions.rip_code;
            if ($urandom_range(99) < 30) hdr.advertised_hops[HOP_W-1:0] = '0;
        end else if (kind < 50) begin
            hdr.dst_addr = decisions.my_addr;
            proto        = decisions.udp_code;
            if ($urandom_range(99) < 70) hdr.src_port = PORT_W'($urandom_range(31));
            if ($urandom_range(99) < 50) hdr.dst_port = PORT_W'($urandom_range(31));
        end else if (kind < 88) begin
            if (hdr.dst_addr == decisions.my_addr)
                hdr.dst_addr = decisions.my_addr ^ ADDR_W'($urandom_range(1, 31));
            if ($urandom_range(99) < 80) hdr.hop_count = HCNT_W'($urandom_range(2));
            if ($urandom_range(99) < 85)
                hdr.hop_list[hdr.hop_count*HOP_W +: HOP_W] = HOP_W'($urandom_range(1, 31));
        end
    endfunction

    // One header transfer, with random gaps ahead of it
    task automatic send_header(input item_t hdr, input logic [PROTO_W-1:0] proto);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(hdr);
        s_tuser  <= proto;
        do @(posedge aclk); while (!s_tready);
        decisions.note_header(hdr, proto);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        decisions.apply_reg(idx, val);
    endtask

    task automatic program_regs(input logic [ADDR_W-1:0] addr, input logic [PROTO_W-1:0] rip,
                                input logic [PROTO_W-1:0] udp, input logic [MASK_W-1:0] mask);
        write_reg(CFG_MY_ADDRESS, CFG_DATA_W'(addr));
        write_reg(CFG_PROTO_RIP, CFG_DATA_W'(rip));
        write_reg(CFG_PROTO_UDP, CFG_DATA_W'(udp));
        write_reg(CFG_PORT_MASK, CFG_DATA_W'(mask));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop offering headers until every decision is back, then let the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (decisions.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        item_t              hdr;
        logic [PROTO_W-1:0] proto;
        decisions = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: route table updates, row fill-up, port checks, forwarding
        program_regs(DIR_NODE, DIR_RIP, DIR_UDP, DIR_MASK);
        send_header(make_hdr(7, DIR_NODE, 0, 0, 0, 0, 0, 20'h12345), DIR_RIP);
        send_header(make_hdr(7, DIR_NODE, 0, 0, 0, 0, 0, 20'h00000), DIR_RIP);
        send_header(make_hdr(7, DIR_NODE, 0, 0, 0, 0, 0, 20'hFFFFF), DIR_RIP);
        send_header(make_hdr(7, DIR_NODE, 0, 0, 0, 0, 0, 20'h00021), DIR_RIP);
        send_header(make_hdr(7, DIR_NODE, 0, 0, 0, 0, 0, 20'h54321), DIR_RIP);  // row full
        send_header(make_hdr(1, DIR_NODE, 0, 0, 0, 0, 0, 0), DIR_UDP);
        send_header(make_hdr(1, DIR_NODE, 0, 0, 0, 1, 31, 0), DIR_UDP);
        send_header(make_hdr(1, DIR_NODE, 0, 0, 0, 2, 32, 0), DIR_UDP);
        send_header(make_hdr(1, DIR_NODE, 0, 0, 0, 255, 255, 0), DIR_UDP);
        send_header(make_hdr(1, DIR_NODE, 0, 0, 0, 200, 10, 0), DIR_UDP);
        send_header(make_hdr(1, DIR_NODE, 0, 0, 0, 31, 0, 0), DIR_UDP);
        send_header(make_hdr(1, DIR_NODE, 0, 0, 0, 0, 0, 0), DIR_OTHER_HI);
        send_header(make_hdr(1, DIR_NODE, 0, 0, 0, 0, 0, 0), DIR_OTHER_LO);
        send_header(make_hdr(2, 7, 0, 0, 20'h0000A, 0, 0, 0), DIR_RIP);
        send_header(make_hdr(2, 7, 1, 1, 20'hFFFFF, 0, 0, 0), DIR_UDP);
        send_header(make_hdr(2, 9, 2, 1, 20'hFFFFF, 0, 0, 0), DIR_UDP);
        send_header(make_hdr(2, 9, 1, 0, 20'h0001F, 0, 0, 0), DIR_UDP);    // empty hop
        send_header(make_hdr(2, 9, 3, 0, 20'hFFFFF, 0, 0, 0), DIR_UDP);    // hop limit
        send_header(make_hdr(31, 31, 0, 1, 20'hFFFFF, 255, 255, 20'hFFFFF), DIR_OTHER_HI);
        send_header(make_hdr(0, 0, 0, 0, 0, 0, 0, 0), DIR_OTHER_LO);
        send_header(make_hdr(31, DIR_NODE, 3, 1, 20'hFFFFF, 255, 255, 20'hFFFFF), DIR_RIP);
        send_header(make_hdr(4, 31, 0, 1, 20'h0001F, 0, 0, 0), DIR_RIP);
        wait_drained();

        // Shared code for both protocols: the update wins
        program_regs(DIR_NODE, DIR_SHARED, DIR_SHARED, 32'h0000_0001);
        send_header(make_hdr(3, DIR_NODE, 0, 0, 0, 0, 0, 20'h00007), DIR_SHARED);
        send_header(make_hdr(4, DIR_NODE, 0, 0, 0, 0, 0, 20'h00003), DIR_SHARED);
        wait_drained();

        // Random phases, each with its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: program_regs('0, RIP_AT_RESET, UDP_AT_RESET, '0);
                1: program_regs('1, 3'd7, 3'd0, '1);
                2: program_regs(ADDR_W'($urandom), 3'd5, 3'd5, $urandom);
                3: program_regs(5'd17, 3'd0, 3'd7, $urandom);
                4: program_regs(ADDR_W'($urandom), PROTO_W'($urandom), PROTO_W'($urandom),
                                32'h8000_0000);
                default: program_regs(ADDR_W'($urandom), 3'd2, 3'd2, $urandom);
            endcase
            case (phase / 2)
                0: begin tx_idle_pct = 9;  rx_idle_pct = 70; end
                1: begin tx_idle_pct = 70; rx_idle_pct = 9;  end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 0 && n == 40) stall_request <= 1'b1;
                if (phase == 3 && n == PHASE_ITEMS / 2) wait_drained();
                random_header(hdr, proto);
                send_header(hdr, proto);
            end
            wait_drained();
        end

        if (decisions.errors == 0 && decisions.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/mpfd_pkg.sv
rtl/mpfd_ram.sv
rtl/mesh_packet_forward_decision_core.sv
rtl/mpfd_checker.sv
tb/sv/testbench.sv
